/* sv/fdl_pkg.sv */
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared widths and defaults of the fractional delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  // Q1.15 samples and a Q.8 delay in samples.
  localparam int unsigned SAMPLE_W          = 16;
  localparam int unsigned DELAY_W           = 20;
  localparam int unsigned FRAC_W            = 8;
  localparam int unsigned DINT_W            = DELAY_W - FRAC_W;
  localparam int unsigned MAX_DELAY_DEFAULT = 4095;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [DELAY_W-1:0]  delay_t;
  typedef logic        [FRAC_W-1:0]   frac_t;

endpackage

/* sv/fractional_delay_line_unit.sv */
// ----------------------------------------------------------------------------
// fractional_delay_line_unit
// Circular sample store with a fractional read tap and linear interpolation.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+------------------------
//  in       | input     | in_valid_i / in_stall_o | sample_in_i  (Q1.15)
//  out      | output    | out_valid_o/ out_stall_i| sample_out_o (Q1.15)
//  cfg      | input     | cfg_we_i                | cfg_wdata_i  (delay Q.8)
//
//  One sample per clock is sustained while the output is not stalled; the
//  store has one write port and two read ports and does the write and both
//  neighbor reads of a sample in the cycle in which it is accepted.
//  A result passes through the stage 1, stage 2 and output registers.
//  Reset clears the pointer and a fill count; entries not yet written read
//  as zero, so no clearing pass over the store is needed.
//  A stall on the output holds the three stages; inputs are still taken
//  until every stage is full.
//
module fractional_delay_line_unit #(
  parameter int unsigned MAX_DELAY = fdl_pkg::MAX_DELAY_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  fdl_pkg::delay_t   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fdl_pkg::sample_t  sample_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fdl_pkg::sample_t  sample_out_o
);
  import fdl_pkg::*;

  localparam int unsigned DEPTH = MAX_DELAY + 1;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW    = ((PTR_W > DINT_W) ? PTR_W : DINT_W) + 1;
  localparam int unsigned PROD_W = SAMPLE_W + 1 + FRAC_W + 1;
  localparam int unsigned SUM_W  = SAMPLE_W + 3;

  localparam logic [31:0]        MaxQ8      = 32'(MAX_DELAY) * 32'd256;
  localparam logic [31:0]        DelayLimit = (32'd1 << DELAY_W) - 32'd1;
  localparam delay_t             DelayReset = (MaxQ8 > DelayLimit) ?
                                              DELAY_W'(DelayLimit) : DELAY_W'(MaxQ8);
  localparam logic [PTR_W-1:0]   LastIdx    = PTR_W'(MAX_DELAY);
  localparam logic [PTR_W:0]     DepthFill  = (PTR_W+1)'(DEPTH);
  localparam logic [AW-1:0]      DepthAw    = AW'(DEPTH);

  // --------------------------------------------------------------------------
  // Control registers and handshakes
  // --------------------------------------------------------------------------
  delay_t             delay_q;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W:0]     fill_q, fill_d;

  logic               s1_v_q, s2_v_q, out_v_q;
  logic               out_ready, s2_ready, s1_ready, in_fire;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign s2_ready   = !s2_v_q || out_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_we_i && ({{(32-DELAY_W){1'b0}}, cfg_wdata_i} <= MaxQ8)) begin
      delay_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Read addresses: integer part of (wp - delay), wrapped, and its neighbor
  // --------------------------------------------------------------------------
  logic [DINT_W-1:0]  dint;
  frac_t              dfrac;
  logic               borrow;
  logic [AW-1:0]      pos_raw, pos_wrap;
  logic [PTR_W-1:0]   idx_a, idx_b;
  frac_t              frac;

  assign dint     = delay_q[DELAY_W-1:FRAC_W];
  assign dfrac    = delay_q[FRAC_W-1:0];
  assign borrow   = (dfrac != '0);
  assign frac     = FRAC_W'(~dfrac + 1'b1);
  assign pos_raw  = AW'(wp_q) - AW'(dint) - AW'(borrow);
  assign pos_wrap = pos_raw[AW-1] ? (pos_raw + DepthAw) : pos_raw;
  assign idx_a    = pos_wrap[PTR_W-1:0];
  assign idx_b    = (idx_a == LastIdx) ? '0 : idx_a + 1'b1;

  // The current write counts toward the fill, so entry wp is already valid.
  logic [PTR_W:0]     fill_next;
  assign fill_next = (fill_q == DepthFill) ? fill_q : fill_q + 1'b1;

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (in_fire) begin
      wp_d   = (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
      fill_d = fill_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sample store: one write port, two read ports, registered read data
  // --------------------------------------------------------------------------
  sample_t mem_q [DEPTH];
  sample_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_q[wp_q] <= sample_in_i;
      rd_a_q      <= mem_q[idx_a];
      rd_b_q      <= mem_q[idx_b];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: select store data, forward the new sample, form the product
  // --------------------------------------------------------------------------
  sample_t  s1_sample_q;
  frac_t    s1_frac_q;
  logic     s1_fwd_a_q, s1_fwd_b_q, s1_zero_a_q, s1_zero_b_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= sample_in_i;
      s1_frac_q   <= frac;
      s1_fwd_a_q  <= (idx_a == wp_q);
      s1_fwd_b_q  <= (idx_b == wp_q);
      s1_zero_a_q <= !({1'b0, idx_a} < fill_next);
      s1_zero_b_q <= !({1'b0, idx_b} < fill_next);
    end
  end

  sample_t                 s1_a, s1_b;
  logic signed [SAMPLE_W:0] s1_diff;
  logic signed [PROD_W-1:0] s1_prod;

  always_comb begin
    priority if (s1_fwd_a_q) begin
      s1_a = s1_sample_q;
    end else if (s1_zero_a_q) begin
      s1_a = '0;
    end else begin
      s1_a = rd_a_q;
    end
    priority if (s1_fwd_b_q) begin
      s1_b = s1_sample_q;
    end else if (s1_zero_b_q) begin
      s1_b = '0;
    end else begin
      s1_b = rd_b_q;
    end
  end

  assign s1_diff = (SAMPLE_W+1)'(s1_b) - (SAMPLE_W+1)'(s1_a);
  assign s1_prod = PROD_W'(s1_diff) * PROD_W'($signed({1'b0, s1_frac_q}));

  // --------------------------------------------------------------------------
  // Stage 2: add the shifted term and saturate into the output register
  // --------------------------------------------------------------------------
  sample_t                  s2_a_q;
  logic signed [PROD_W-1:0] s2_prod_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_ready) begin
      s2_a_q    <= s1_a;
      s2_prod_q <= s1_prod;
    end
  end

  logic signed [PROD_W-FRAC_W-1:0] s2_term;
  logic signed [SUM_W-1:0]         s2_sum;
  sample_t                         s2_sat;

  // Dropping the low bits of a signed product is a floor division by 256.
  assign s2_term = s2_prod_q[PROD_W-1:FRAC_W];
  assign s2_sum  = SUM_W'(s2_a_q) + SUM_W'(s2_term);

  always_comb begin
    priority if (s2_sum > SUM_W'(32'sd32767)) begin
      s2_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (s2_sum < -SUM_W'(32'sd32768)) begin
      s2_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      s2_sat = s2_sum[SAMPLE_W-1:0];
    end
  end

  sample_t out_q;

  always_ff @(posedge clk_i) begin
    if (s2_v_q && out_ready) begin
      out_q <= s2_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_fire;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthFill)
    else $error("fill count exceeds store depth");

  a_wp_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != DepthFill) |-> (wp_q == fill_q[PTR_W-1:0]))
    else $error("write pointer diverged from fill count before wrap");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (idx_a <= LastIdx))
    else $error("read address outside the store");

  // Unwritten entries read as unknown, so the comparison is a case equality.
  a_held_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s2_ready) |=>
      ((rd_a_q === $past(rd_a_q)) && (rd_b_q === $past(rd_b_q))))
    else $error("store read data changed while stage 1 was held");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && fill_q != DepthFill) |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("fill count did not advance on an accepted transaction");

endmodule

/* test/fdl_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdl_scoreboard_pkg
// Predicts the delayed, interpolated output of the fractional delay line and
// compares every output transaction against it in order.
// ----------------------------------------------------------------------------
package fdl_scoreboard_pkg;
  import fdl_pkg::*;

  localparam int unsigned LINE_DEPTH   = MAX_DELAY_DEFAULT + 1;
  localparam int unsigned MAX_TAP_Q8   = MAX_DELAY_DEFAULT * 256;
  localparam int          SAMPLE_MAX   = 32767;
  localparam int          SAMPLE_MIN   = -32768;

  class delay_line_scoreboard;
    sample_t     history [LINE_DEPTH];
    int unsigned wr_ptr;
    delay_t      tap_delay;
    sample_t     expected_q [$];
    int unsigned n_errors;
    int unsigned n_samples;
    int unsigned n_results;
    int unsigned n_writes;
    int unsigned n_ignored;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_ptr    = 0;
      tap_delay = delay_t'(MAX_TAP_Q8);
      n_errors  = 0;
      n_samples = 0;
      n_results = 0;
      n_writes  = 0;
      n_ignored = 0;
    endfunction

    // A delay beyond the length of the line leaves the old setting in place.
    function void write_delay(delay_t value);
      n_writes++;
      if (value > delay_t'(MAX_TAP_Q8)) begin
        n_ignored++;
      end else begin
        tap_delay = value;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // The new sample is stored first, so a zero delay reads it straight back.
    function void note_sample(sample_t x);
      int          pos;
      int unsigned idx;
      int unsigned nxt;
      int          frac;
      int          a;
      int          b;
      int          y;
      n_samples++;
      history[wr_ptr] = x;
      pos = int'(wr_ptr) * 256 - int'(tap_delay);
      if (pos < 0) pos += int'(LINE_DEPTH) * 256;
      idx  = pos / 256;
      frac = pos % 256;
      nxt  = (idx + 1 == LINE_DEPTH) ? 0 : idx + 1;
      a = history[idx];
      b = history[nxt];
      y = a + (((b - a) * frac) >>> 8);
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      else if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      expected_q.push_back(sample_t'(y));
      wr_ptr = (wr_ptr + 1 == LINE_DEPTH) ? 0 : wr_ptr + 1;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      n_errors++;
    endtask

    task check_result(sample_t got);
      sample_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        report($sformatf("output %0d arrived with no sample waiting", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          report($sformatf("output %0d: sample_out %0d, expected %0d",
                           n_results, got, want));
        end
      end
    endtask
  endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Directed and random test of the fractional delay line unit: samples and
// delay settings are driven with random gaps and output stalls, and each
// output is checked against a predicted copy of the line.
// ----------------------------------------------------------------------------
module tb;
  import fdl_pkg::*;
  import fdl_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 106;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    cfg_we_i    = 1'b0;
  delay_t  cfg_wdata_i = '0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  sample_t sample_in_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  sample_t sample_out_o;

  delay_line_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  bit          tx_quiet      = 1'b0;
  bit          rx_quiet      = 1'b0;
  bit          long_hold_req = 1'b0;

  fractional_delay_line_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("Timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // Outputs are checked before the same edge's input is noted; the block
  // cannot return a sample in the cycle that it takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(sample_out_o);
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_in_i);
      if (cfg_we_i) sb.write_delay(cfg_wdata_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample(sample_t prev);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
      1, 2: return prev + sample_t'($urandom_range(0, 511) - 256);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: alternating runs of ready and stalled cycles, one long
  // hold-off on request, or no stalls at all in quiet phases.
  initial begin
    bit stall;
    int unsigned len;
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        stall = ($urandom_range(0, 99) < 35);
        len   = stall ? pick_gap() + 1 : $urandom_range(1, 8);
        out_stall_i <= stall;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(sample_t value);
    int unsigned gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_delay(delay_t value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic delay_t pick_delay();
    int unsigned span;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return delay_t'(MAX_TAP_Q8);
      2: return delay_t'($urandom_range(0, 20'hFFFFF));
      default: begin
        // Mostly reach back into samples that have already been written.
        span = (sb.wr_ptr > 300) ? 300 : sb.wr_ptr;
        return delay_t'($urandom_range(0, span) * 256 + $urandom_range(0, 255));
      end
    endcase
  endfunction

  initial begin
    sample_t prev;
    prev = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset delay spans the whole line, so only unwritten entries, which read as zero, are read.
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));

    write_delay('0);
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));

    // Half a sample between full-scale opposite samples.
    write_delay(delay_t'(20'h00080));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));

    write_delay(delay_t'(20'h001FF));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(12345));

    // Both writes exceed the line length and must leave the delay unchanged.
    write_delay(delay_t'(MAX_TAP_Q8 + 1));
    write_delay(delay_t'(20'hFFFFF));
    send_sample(sample_t'(100));
    send_sample(sample_t'(-100));

    write_delay(delay_t'(MAX_TAP_Q8));
    send_sample(sample_t'(7));

    // Tap lands between the last entry and its wrapped neighbor, entry zero.
    // The line is drained first so that the predicted pointer is current.
    wait_idle();
    write_delay(delay_t'(sb.wr_ptr * 256 + 128));
    send_sample(sample_t'(-5));
    send_sample(sample_t'(3));

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      write_delay((p == 0) ? delay_t'($urandom_range(1, 4095)) : pick_delay());
      tx_quiet = (p == 2 || p == 5 || p == 3);
      rx_quiet = (p == 2 || p == 5);
      if (p == 3) long_hold_req = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        prev = pick_sample(prev);
        send_sample(prev);
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d outputs never arrived", sb.pending()));

    $display("Ran %0d samples and checked %0d outputs across %0d delay writes (%0d rejected).",
             sb.n_samples, sb.n_results, sb.n_writes, sb.n_ignored);
    $display("Output was held off for %0d cycles once with input still offered.", LONG_HOLD);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
